FILE: hdl/prbr_pkg.sv
// Package for the packet ring buffer: field widths, command and status codes,
// and the item type carried from the front end through the queue to the back end.
// No dependencies.
package prbr_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int FILL_W   = 11;
    localparam int LOG2_W   = 4;

    // Command codes as they arrive on the slave tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_RESERVE  = 3'd1,
        CMD_COMPLETE = 3'd2,
        CMD_REWIND   = 3'd3,
        CMD_READ     = 3'd4,
        CMD_FLUSH    = 3'd5,
        CMD_COUNT    = 3'd6
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_DATA = 2'd1,
        ST_NO_ROOM = 2'd2
    } status_t;

    // Classified command as held in the queue
    typedef struct packed {
        cmd_t              cmd;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] byte_value;
        logic [LEN_W-1:0]  length;
    } item_t;

    // Handshake between the queue and the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

FILE: hdl/prbr_front.sv
// Front end of the packet ring buffer: accepts command beats, decodes the
// command code and saturates the length. Depends on prbr_pkg.
module prbr_front #(
    parameter int MAX_PACKET = 64
) (
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // s_axis_tdata: position [9:0], byte_value [17:10], length [24:18]
    input  logic [31:0]                  s_axis_tdata,
    // s_axis_tuser: command [2:0]
    input  logic [prbr_pkg::CMD_W-1:0]   s_axis_tuser,
    input  logic                         queue_full,
    output logic                         push,
    output prbr_pkg::item_t              push_item
);
    import prbr_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PACKET);

    logic [LEN_W-1:0] raw_len;
    cmd_t             cmd_dec;

    // Accept whenever the queue has a free slot
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    // Decode: an unknown code behaves as a count query
    always_comb
    begin
        unique case (s_axis_tuser) inside
            CMD_WRITE, CMD_RESERVE, CMD_COMPLETE, CMD_REWIND,
            CMD_READ, CMD_FLUSH, CMD_COUNT:
                cmd_dec = cmd_t'(s_axis_tuser);
            default:
                cmd_dec = CMD_COUNT;
        endcase
    end

    // Clamp the length to the largest packet
    assign raw_len = s_axis_tdata[24:18];

    always_comb
    begin
        push_item.cmd        = cmd_dec;
        push_item.position   = s_axis_tdata[9:0];
        push_item.byte_value = s_axis_tdata[17:10];
        push_item.length     = (raw_len > MaxLen) ? MaxLen : raw_len;
    end

endmodule

FILE: hdl/prbr_queue.sv
// Two-slot command queue between the front end and the back end of the
// packet ring buffer. Depends on prbr_pkg.
module prbr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  prbr_pkg::item_t       push_item,
    output logic                  full,
    input  logic                  pop,
    output prbr_pkg::queue_head_t head
);
    import prbr_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload in the slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/prbr_back.sv
// Back end of the packet ring buffer: pointer state, byte store, size register
// and the registered result beat. Depends on prbr_pkg.
module prbr_back #(
    parameter int DEPTH_LOG2 = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [prbr_pkg::LOG2_W-1:0]   cfg_wdata,
    input  prbr_pkg::queue_head_t         head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [prbr_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last,
    output prbr_pkg::status_t             out_status,
    output logic [prbr_pkg::START_W-1:0]  out_start,
    output logic [prbr_pkg::FILL_W-1:0]   out_fill
);
    import prbr_pkg::*;

    localparam int AW    = DEPTH_LOG2;
    localparam int PW    = DEPTH_LOG2 + 1;
    localparam int CW    = (PW > LEN_W) ? PW : LEN_W;
    localparam int SW    = CW + 1;
    localparam int DEPTH = 1 << DEPTH_LOG2;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [LOG2_W-1:0]    size_log2_reg;
    logic [PW-1:0]        read_reg;
    logic [PW-1:0]        read_next;
    logic [PW-1:0]        commit_reg;
    logic [PW-1:0]        commit_next;
    logic [PW-1:0]        pend_reg;
    logic [PW-1:0]        pend_next;
    logic [LEN_W-1:0]     cnt_reg;
    logic [LEN_W-1:0]     cnt_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [BYTE_W-1:0]    out_byte_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    status_t              out_status_reg;
    status_t              out_status_next;
    logic [START_W-1:0]   out_start_reg;
    logic [START_W-1:0]   out_start_next;
    logic [FILL_W-1:0]    out_fill_reg;
    logic [FILL_W-1:0]    out_fill_next;

    logic [7:0]           store_mem [DEPTH];
    logic [BYTE_W-1:0]    rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;

    logic [4:0]           act_log2;
    logic [PW-1:0]        size_vec;
    logic [PW-1:0]        mask_pw;
    logic [AW-1:0]        mask_aw;
    logic [PW-1:0]        fill_now;
    logic [PW-1:0]        used_now;
    logic [PW-1:0]        fill_after;
    logic                 out_free;
    logic                 out_load;
    item_t                it;

    // Clamp the size register into the usable range and derive the mask
    always_comb
    begin
        act_log2 = 5'(size_log2_reg);
        if (act_log2 == 5'd0)
        begin
            act_log2 = 5'd1;
        end
        else if (act_log2 > 5'(DEPTH_LOG2))
        begin
            act_log2 = 5'(DEPTH_LOG2);
        end
    end

    assign size_vec = PW'(1) << act_log2;
    assign mask_pw  = size_vec - PW'(1);
    assign mask_aw  = mask_pw[AW-1:0];

    assign fill_now = commit_reg - read_reg;
    assign used_now = pend_reg - read_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign it       = head.item;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;
    assign out_fill   = out_fill_reg;

    // Execute one command or stream one byte per cycle while the output beat is free
    always_comb
    begin
        state_next      = state_reg;
        read_next       = read_reg;
        commit_next     = commit_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop             = 1'b1;
                    out_load        = 1'b1;
                    out_byte_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    out_start_next  = '0;
                    unique case (it.cmd)
                        CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        CMD_RESERVE:
                        begin
                            if (SW'(used_now) + SW'(it.length) > SW'(size_vec))
                            begin
                                out_status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                out_start_next = START_W'(pend_reg[AW-1:0] & mask_aw);
                                pend_next      = pend_reg + PW'(it.length);
                            end
                        end
                        CMD_COMPLETE:
                        begin
                            commit_next = pend_reg;
                        end
                        CMD_REWIND:
                        begin
                            commit_next    = commit_reg - PW'(it.length);
                            out_start_next = START_W'(commit_next[AW-1:0] & mask_aw);
                        end
                        CMD_READ:
                        begin
                            if ((CW'(fill_now) < CW'(it.length)) || (commit_reg == read_reg))
                            begin
                                out_status_next = ST_NO_DATA;
                            end
                            else if (it.length != '0)
                            begin
                                // Hand over to the byte stream
                                out_load   = 1'b0;
                                state_next = S_STREAM;
                                cnt_next   = it.length;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            read_next = commit_reg;
                        end
                        CMD_COUNT:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_STREAM:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = rdata_reg;
                    out_last_next   = (cnt_reg == LEN_W'(1));
                    out_status_next = ST_OK;
                    out_start_next  = '0;
                    read_next       = read_reg + PW'(1);
                    cnt_next        = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fill_after    = commit_next - read_next;
        out_fill_next = out_load ? FILL_W'(fill_after) : out_fill_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Store addresses: write by position, read ahead at the next read pointer
    assign wr_addr = AW'(it.position) & mask_aw;
    assign rd_addr = read_next[AW-1:0] & mask_aw;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= it.byte_value;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    // Hold state, pointers, size and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            size_log2_reg  <= LOG2_W'(10);
            read_reg       <= '0;
            commit_reg     <= '0;
            pend_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= ST_OK;
            out_start_reg  <= '0;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wen)
            begin
                size_log2_reg <= cfg_wdata;
            end
            read_reg       <= read_next;
            commit_reg     <= commit_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
            out_start_reg  <= out_start_next;
            out_fill_reg   <= out_fill_next;
        end
    end

endmodule

FILE: hdl/packet_ring_buffer_with_reservation_top.sv
// Packet ring buffer with reservation. Pointer commands give one result each,
// one command per cycle sustained while the receiver takes every beat; a result
// beat passes through the command queue and the registered output beat. A packet
// read of n bytes streams n beats, one per cycle while the receiver is ready; the
// first byte beat also passes through the registered read of the byte store.
// Reset clears the pointers, the queue and the output beat and sets size_log2
// to 10; the byte store is not cleared and holds unknown data until written.
module packet_ring_buffer_with_reservation_top #(
    parameter int DEPTH_LOG2 = 10,
    parameter int MAX_PACKET = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [prbr_pkg::LOG2_W-1:0]   cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // s_axis_tdata: position [9:0], byte_value [17:10], length [24:18]
    input  logic [31:0]                   s_axis_tdata,
    // s_axis_tuser: command [2:0]
    input  logic [prbr_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // m_axis_tdata: byte_out [7:0], start_position [17:8], fill_count [28:18]
    output logic [31:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,
    // m_axis_tuser: status [1:0]
    output logic [prbr_pkg::STATUS_W-1:0] m_axis_tuser
);
    import prbr_pkg::*;

    logic                 push;
    item_t                push_item;
    logic                 queue_full;
    logic                 pop;
    queue_head_t          head;
    logic [BYTE_W-1:0]    out_byte;
    status_t              out_status;
    logic [START_W-1:0]   out_start;
    logic [FILL_W-1:0]    out_fill;

    // Accept and classify
    prbr_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Decouple front and back
    prbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    // Execute commands
    prbr_back #(
        .DEPTH_LOG2 (DEPTH_LOG2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_last   (m_axis_tlast),
        .out_status (out_status),
        .out_start  (out_start),
        .out_fill   (out_fill)
    );

    // Pack the result beat
    assign m_axis_tdata = {3'b000, out_fill, out_start, out_byte};
    assign m_axis_tuser = out_status;

endmodule

FILE: tb/packet_ring_buffer_with_reservation_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the packet ring buffer with reservation: command beats
// in, result beats out, checked against an in-bench ring buffer tracker.
// Depends on prbr_pkg and packet_ring_buffer_with_reservation_top.
module packet_ring_buffer_with_reservation_top_tb;

    import prbr_pkg::*;

    localparam int DEPTH_LOG2    = 10;
    localparam int STORE_DEPTH   = 1 << DEPTH_LOG2;
    localparam int MAX_LEN       = 64;
    localparam int PHASE_ITEMS   = 73;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;

    // Opcode that the block treats as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // Buffer sizes (log2) for the random phases, phase 0 in the lowest nibble
    localparam logic [5:0][LOG2_W-1:0] PHASE_SIZES =
        {4'd8, 4'd2, 4'd10, 4'd6, 4'd1, 4'd15};

    typedef struct {
        logic [BYTE_W-1:0]  byte_out;
        logic               last;
        status_t            status;
        logic [START_W-1:0] start_pos;
        logic [FILL_W-1:0]  fill;
    } ring_beat_t;

    // Tracks the pointers, the byte store and the beats still due from the block
    class ring_tracker;
        logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
        bit                written   [STORE_DEPTH];
        logic [FILL_W-1:0] rd_ptr;
        logic [FILL_W-1:0] commit_ptr;
        logic [FILL_W-1:0] pend_ptr;
        logic [LOG2_W-1:0] size_reg;
        ring_beat_t        due_beats [$];
        int                mismatches;
        bit                reserve_ok;
        logic [POS_W-1:0]  reserve_start;

        function new();
            for (int i = 0; i < STORE_DEPTH; i++) begin
                written[i]   = 1'b0;
                store_mem[i] = '0;
            end
            rd_ptr        = '0;
            commit_ptr    = '0;
            pend_ptr      = '0;
            size_reg      = 4'd10;
            mismatches    = 0;
            reserve_ok    = 1'b0;
            reserve_start = '0;
        endfunction

        function void set_size(logic [LOG2_W-1:0] value);
            size_reg = value;
        endfunction

        // Clamp the size register into the supported range
        function int unsigned span_log2();
            if (size_reg < 1) return 1;
            if (size_reg > DEPTH_LOG2) return DEPTH_LOG2;
            return size_reg;
        endfunction

        function logic [POS_W-1:0] pos_mask();
            return POS_W'((1 << span_log2()) - 1);
        endfunction

        function logic [FILL_W-1:0] fill_level();
            return commit_ptr - rd_ptr;
        endfunction

        function int unsigned clamp_len(logic [LEN_W-1:0] len);
            return (len > MAX_LEN) ? MAX_LEN : len;
        endfunction

        function int outstanding();
            return due_beats.size();
        endfunction

        // True when a packet read of len touches only bytes that were stored, or is refused or empty
        function bit read_is_safe(logic [LEN_W-1:0] len);
            int unsigned      n;
            logic [FILL_W-1:0] p;
            logic [POS_W-1:0]  mask;
            n    = clamp_len(len);
            mask = pos_mask();
            if (fill_level() < n || commit_ptr == rd_ptr || n == 0) return 1'b1;
            p = rd_ptr;
            for (int k = 0; k < n; k++) begin
                if (!written[p[POS_W-1:0] & mask]) return 1'b0;
                p = p + 11'd1;
            end
            return 1'b1;
        endfunction

        // Apply one accepted command and queue the beats it produces
        function void take_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [BYTE_W-1:0] val, logic [LEN_W-1:0] len);
            ring_beat_t        beat;
            int unsigned       span;
            int unsigned       n;
            logic [POS_W-1:0]  mask;
            logic [FILL_W-1:0] used;
            span           = 1 << span_log2();
            mask           = pos_mask();
            n              = clamp_len(len);
            beat.byte_out  = '0;
            beat.last      = 1'b1;
            beat.status    = ST_OK;
            beat.start_pos = '0;
            case (op)
                CMD_WRITE: begin
                    store_mem[pos & mask] = val;
                    written[pos & mask]   = 1'b1;
                end
                CMD_RESERVE: begin
                    used       = pend_ptr - rd_ptr;
                    reserve_ok = (used + n <= span);
                    if (!reserve_ok) begin
                        beat.status = ST_NO_ROOM;
                    end
                    else begin
                        reserve_start  = pend_ptr[POS_W-1:0] & mask;
                        beat.start_pos = reserve_start;
                        pend_ptr       = pend_ptr + FILL_W'(n);
                    end
                end
                CMD_COMPLETE: begin
                    commit_ptr = pend_ptr;
                end
                CMD_REWIND: begin
                    commit_ptr     = commit_ptr - FILL_W'(n);
                    beat.start_pos = commit_ptr[POS_W-1:0] & mask;
                end
                CMD_READ: begin
                    if (fill_level() < n || commit_ptr == rd_ptr) begin
                        beat.status = ST_NO_DATA;
                    end
                    else if (n != 0) begin
                        // Stream one beat per byte, advancing the read pointer
                        for (int k = 0; k < n; k++) begin
                            beat.byte_out = store_mem[rd_ptr[POS_W-1:0] & mask];
                            rd_ptr        = rd_ptr + 11'd1;
                            beat.last     = (k == n - 1);
                            beat.fill     = fill_level();
                            due_beats.push_back(beat);
                        end
                        return;
                    end
                end
                CMD_FLUSH: begin
                    rd_ptr = commit_ptr;
                end
                default: ;  // count and the unused opcode change nothing
            endcase
            beat.fill = fill_level();
            due_beats.push_back(beat);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one result beat with the oldest beat due
        task match_beat(logic [BYTE_W-1:0] b, logic l, logic [STATUS_W-1:0] st,
                        logic [START_W-1:0] sp, logic [FILL_W-1:0] f);
            ring_beat_t want;
            if (due_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat byte %02h fill %0d", b, f));
                return;
            end
            want = due_beats.pop_front();
            if (b !== want.byte_out || l !== want.last || st !== want.status ||
                sp !== want.start_pos || f !== want.fill)
                report_mismatch($sformatf(
                    "byte %02h/%02h last %0b/%0b status %0d/%0d start %0d/%0d fill %0d/%0d",
                    b, want.byte_out, l, want.last, st, want.status,
                    sp, want.start_pos, f, want.fill));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [LOG2_W-1:0]   cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;
    logic [CMD_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;
    logic                m_axis_tlast;
    logic [STATUS_W-1:0] m_axis_tuser;

    int send_idle_pct = 16;
    int recv_idle_pct = 88;

    ring_tracker tracker = new();

    packet_ring_buffer_with_reservation_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock, 2 ns period
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every result beat taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_beat(m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser,
                               m_axis_tdata[17:8], m_axis_tdata[28:18]);
    end

    // Watchdog: end the run after too many cycles with no beat moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one command beat, hold it until accepted, then record it
    task automatic send(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                        input logic [BYTE_W-1:0] val, input logic [LEN_W-1:0] len);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, len, val, pos};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_command(op, pos, val, len);
    endtask

    // Drop valid and wait until every due beat has come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // Write the size register while the block is idle
    task automatic write_size(input logic [LOG2_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        tracker.set_size(value);
    endtask

    // Reserve, fill, usually commit, then read back or flush one packet with random content
    task automatic packet_sequence(inout int sent);
        int               span;
        int               n;
        int               rd_len;
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] mask;
        span = 1 << tracker.span_log2();
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(0, (span < MAX_LEN) ? span : MAX_LEN);
        else
            n = $urandom_range(0, (span < 8) ? span : 8);
        send(CMD_RESERVE, POS_W'($urandom), BYTE_W'($urandom), LEN_W'(n));
        sent++;
        if (!tracker.reserve_ok) return;
        base = tracker.reserve_start;
        mask = tracker.pos_mask();
        // Upper position bits beyond the mask are random and must be ignored
        for (int k = 0; k < n; k++)
        begin
            send(CMD_WRITE, POS_W'(((base + k) & mask) | ($urandom & ~mask)),
                 BYTE_W'($urandom), LEN_W'($urandom));
            sent++;
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send(CMD_COMPLETE, POS_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
            sent++;
        end
        rd_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n + 2) : n;
        // Skip over stale data rather than read bytes never stored
        if (tracker.read_is_safe(LEN_W'(rd_len)))
            send(CMD_READ, POS_W'($urandom), BYTE_W'($urandom), LEN_W'(rd_len));
        else
            send(CMD_FLUSH, POS_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
        sent++;
    endtask

    // One command with random opcode and fields
    task automatic noise_item();
        logic [CMD_W-1:0] op;
        logic [LEN_W-1:0] len;
        int               span;
        span = 1 << tracker.span_log2();
        op   = CMD_W'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            len = LEN_W'($urandom);
        else
            len = LEN_W'($urandom_range(0, (span < MAX_LEN) ? span : MAX_LEN));
        if (op == CMD_READ && !tracker.read_is_safe(len))
            len = '0;
        send(op, POS_W'($urandom), BYTE_W'($urandom), len);
    endtask

    initial
    begin
        int sent;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty buffer: count, zero-length and short reads both refused
        send(CMD_COUNT, '0, '0, '0);
        send(CMD_READ, '0, '0, 7'd0);
        send(CMD_READ, '0, '0, 7'd3);
        // One four-byte packet with extreme data values
        send(CMD_RESERVE, '0, '0, 7'd4);
        send(CMD_WRITE, 10'd0, 8'h00, '0);
        send(CMD_WRITE, 10'd1, 8'hFF, '0);
        send(CMD_WRITE, 10'd2, 8'hA5, '0);
        send(CMD_WRITE, 10'd3, 8'h5A, '0);
        send(CMD_COMPLETE, '0, '0, '0);
        send(CMD_READ, '0, '0, 7'd0);
        send(CMD_READ, '0, '0, 7'd5);
        send(CMD_READ, '0, '0, 7'd4);
        // Top position, oversized reservation, rewind past the read pointer
        send(CMD_WRITE, 10'd1023, 8'hFF, 7'd127);
        send(CMD_RESERVE, 10'd1023, 8'hFF, 7'd127);
        send(CMD_REWIND, '0, '0, 7'd100);
        send(CMD_COUNT, '0, '0, '0);
        send(CMD_FLUSH, '0, '0, '0);
        send(CMD_UNUSED, 10'd1023, 8'hFF, 7'd127);
        send(CMD_COMPLETE, '0, '0, '0);
        send(CMD_FLUSH, '0, '0, '0);
        // Size register below range: reservation too big for two bytes
        write_size(4'd0);
        send(CMD_RESERVE, '0, '0, 7'd3);
        send(CMD_RESERVE, '0, '0, 7'd2);

        // Random phases, each with its own size and idle pattern
        for (int p = 0; p < 6; p++)
        begin
            write_size(PHASE_SIZES[p]);
            send_idle_pct = (p < 2) ? 16 : (p < 4) ? 88 : 0;
            recv_idle_pct = (p < 2) ? 88 : (p < 4) ? 16 : 0;
            send(CMD_COMPLETE, POS_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
            send(CMD_FLUSH, POS_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
            sent = 2;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 6)
                    packet_sequence(sent);
                else
                begin
                    noise_item();
                    sent++;
                end
            end
        end

        // Let late or extra beats show up before the verdict
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/prbr_pkg.sv
hdl/prbr_front.sv
hdl/prbr_queue.sv
hdl/prbr_back.sv
hdl/packet_ring_buffer_with_reservation_top.sv
tb/packet_ring_buffer_with_reservation_top_tb.sv
